// ===== hw/rtl/esc_pkg.sv =====
package esc_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIXED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM45   = 3'd4;

	localparam logic signed [63:0] TEMP_MIN   = -64'sd4000;
	localparam logic signed [63:0] TEMP_MAX   = 64'sd8500;
	localparam logic [31:0]        PRESS_MIN  = 32'd3000000;
	localparam logic [31:0]        PRESS_MAX  = 32'd11000000;
	localparam logic signed [63:0] HUM_MAX    = 64'sd419430400;

	typedef struct packed {
		logic        any;
		logic        do_press;
		logic        do_hum;
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		logic [15:0] raw_h;
	} job_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [11:0] h4;
		logic [11:0] h5;
		logic [7:0]  h6;
	} coef_t;

	// Signed division by 2^k that truncates toward zero.
	function automatic logic signed [63:0] div_p2(input logic signed [63:0] x,
			input int unsigned k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

// ===== hw/rtl/esc_front.sv =====
module esc_front #(
	parameter int Depth = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           mode,
	input  logic [19:0]          raw_temperature,
	input  logic [19:0]          raw_pressure,
	input  logic [15:0]          raw_humidity,
	output logic                 q_valid,
	output esc_pkg::job_t        q_data,
	input  logic                 q_pop
);
	import esc_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	job_t          mem_q [Depth];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	job_t          job;

	// Classify the sample: which compensation paths the back end has to run.
	always_comb begin
		job.any      = (mode != 3'd0);
		job.do_press = mode[0];
		job.do_hum   = mode[2];
		job.raw_t    = raw_temperature;
		job.raw_p    = raw_pressure;
		job.raw_h    = raw_humidity;
	end

	assign in_stall = (count_q == CW'(Depth));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/esc_mul.sv =====
module esc_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);
	import esc_pkg::*;

	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HL = 2'd2;

	logic [63:0] a_q, b_q;
	logic [31:0] lo_q, hi_q;
	logic [1:0]  ph_q;
	logic        busy_q, done_q;
	logic [31:0] op_a, op_b;
	logic [63:0] prod;

	// Low 64 bits of the product from three 32x32 partial products.
	always_comb begin
		unique case (ph_q)
			PH_LL: begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
			PH_LH: begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
			PH_HL: begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
			default: begin op_a = a_q[31:0]; op_b = b_q[31:0]; end
		endcase
	end

	assign prod   = 64'(op_a) * 64'(op_b);
	assign done   = done_q;
	assign result = {hi_q, lo_q};

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			unique case (ph_q)
				PH_LL: begin
					lo_q <= prod[31:0];
					hi_q <= prod[63:32];
				end
				default: hi_q <= hi_q + prod[31:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_LL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ph_q   <= PH_LL;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ph_q == PH_HL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/esc_div.sv =====
module esc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);
	import esc_pkg::*;

	localparam int DivBits = 64;
	localparam int CntW    = $clog2(DivBits);

	logic [63:0]     rem_q, quo_q, den_q;
	logic            neg_q, zero_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q, done_q;
	logic [64:0]     shifted, diff;

	assign shifted = {rem_q, quo_q[63]};
	assign diff    = shifted - {1'b0, den_q};
	assign done    = done_q;
	// Magnitudes are divided; the sign is put back at the end. A zero divisor gives zero.
	assign result  = zero_q ? 64'd0 : (neg_q ? (64'd0 - quo_q) : quo_q);

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= a[63] ^ b[63];
			zero_q <= (b == 64'd0);
			quo_q  <= a[63] ? (64'd0 - a) : a;
			den_q  <= b[63] ? (64'd0 - b) : b;
			rem_q  <= 64'd0;
		end else if (busy_q) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DivBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/esc_back.sv =====
module esc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  esc_pkg::job_t       q_data,
	output logic                q_pop,
	input  esc_pkg::coef_t      coef,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [14:0]  temperature_out,
	output logic [23:0]         pressure_out,
	output logic [16:0]         humidity_out
);
	import esc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam int NUM_STEPS = 23;
	localparam int SW        = $clog2(NUM_STEPS);

	localparam logic [SW-1:0] STP_T_A   = 5'd0;
	localparam logic [SW-1:0] STP_T_BB  = 5'd1;
	localparam logic [SW-1:0] STP_T_C   = 5'd2;
	localparam logic [SW-1:0] STP_P_SQ  = 5'd3;
	localparam logic [SW-1:0] STP_P_SQ6 = 5'd4;
	localparam logic [SW-1:0] STP_P_V5  = 5'd5;
	localparam logic [SW-1:0] STP_P_SQ3 = 5'd6;
	localparam logic [SW-1:0] STP_P_V2  = 5'd7;
	localparam logic [SW-1:0] STP_P_P1  = 5'd8;
	localparam logic [SW-1:0] STP_P_NUM = 5'd9;
	localparam logic [SW-1:0] STP_P_DIV = 5'd10;
	localparam logic [SW-1:0] STP_P_W9  = 5'd11;
	localparam logic [SW-1:0] STP_P_WW  = 5'd12;
	localparam logic [SW-1:0] STP_P_P8  = 5'd13;
	localparam logic [SW-1:0] STP_P_SCL = 5'd14;
	localparam logic [SW-1:0] STP_H_X5  = 5'd15;
	localparam logic [SW-1:0] STP_H_X6  = 5'd16;
	localparam logic [SW-1:0] STP_H_X3  = 5'd17;
	localparam logic [SW-1:0] STP_H_AB  = 5'd18;
	localparam logic [SW-1:0] STP_H_C2  = 5'd19;
	localparam logic [SW-1:0] STP_H_DA  = 5'd20;
	localparam logic [SW-1:0] STP_H_QQ  = 5'd21;
	localparam logic [SW-1:0] STP_H_H1  = 5'd22;

	logic [1:0]         state_q;
	logic [SW-1:0]      step_q, next_step;
	logic               last_step;
	job_t               job_q;
	logic signed [63:0] res_q [NUM_STEPS];

	logic               mul_start, div_start, mul_done, div_done, unit_done;
	logic [63:0]        mul_res, div_res, unit_res;
	logic signed [63:0] op_a, op_b;

	logic signed [63:0] t1u, t2s, t3s, p1u, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
	logic signed [63:0] h1u, h2s, h3u, h4s, h5s, h6s;
	logic signed [63:0] t_a, t_b, tf, v1, v2, v1c, w, v4c, hx, hd, hq, hd2, tt;
	logic [31:0]        p32;
	logic signed [14:0] temp_n;
	logic [23:0]        press_n;
	logic [16:0]        hum_n;
	logic               out_free;

	assign t1u = $signed({48'd0, coef.t1});
	assign t2s = $signed({{48{coef.t2[15]}}, coef.t2});
	assign t3s = $signed({{48{coef.t3[15]}}, coef.t3});
	assign p1u = $signed({48'd0, coef.p1});
	assign p2s = $signed({{48{coef.p2[15]}}, coef.p2});
	assign p3s = $signed({{48{coef.p3[15]}}, coef.p3});
	assign p4s = $signed({{48{coef.p4[15]}}, coef.p4});
	assign p5s = $signed({{48{coef.p5[15]}}, coef.p5});
	assign p6s = $signed({{48{coef.p6[15]}}, coef.p6});
	assign p7s = $signed({{48{coef.p7[15]}}, coef.p7});
	assign p8s = $signed({{48{coef.p8[15]}}, coef.p8});
	assign p9s = $signed({{48{coef.p9[15]}}, coef.p9});
	assign h1u = $signed({56'd0, coef.h1});
	assign h2s = $signed({{48{coef.h2[15]}}, coef.h2});
	assign h3u = $signed({56'd0, coef.h3});
	assign h4s = $signed({{52{coef.h4[11]}}, coef.h4});
	assign h5s = $signed({{52{coef.h5[11]}}, coef.h5});
	assign h6s = $signed({{56{coef.h6[7]}}, coef.h6});

	// Values between steps, built from stored step results.
	assign t_a = $signed({47'd0, job_q.raw_t[19:3]}) - $signed({47'd0, coef.t1, 1'b0});
	assign t_b = $signed({48'd0, job_q.raw_t[19:4]}) - t1u;
	assign tf  = div_p2(res_q[STP_T_A], 11) + div_p2(res_q[STP_T_C], 14);
	assign v1  = tf - 64'sd128000;
	assign v2  = res_q[STP_P_SQ6] + (res_q[STP_P_V5] <<< 17) + (p4s <<< 35);
	assign v1c = div_p2(res_q[STP_P_P1], 33);
	assign w   = div_p2(res_q[STP_P_DIV], 13);
	assign v4c = div_p2(res_q[STP_P_DIV] + div_p2(res_q[STP_P_WW], 25)
			+ div_p2(res_q[STP_P_P8], 19), 8) + (p7s <<< 4);
	assign hx  = tf - 64'sd76800;
	assign hd  = div_p2($signed({34'd0, job_q.raw_h, 14'd0}) - (h4s <<< 20)
			- res_q[STP_H_X5] + 64'sd16384, 15);
	assign hq  = div_p2(res_q[STP_H_DA], 15);
	assign hd2 = res_q[STP_H_DA] - div_p2(res_q[STP_H_H1], 4);

	always_comb begin
		op_a = 64'sd0;
		op_b = 64'sd0;
		unique case (step_q)
			STP_T_A:   begin op_a = t_a; op_b = t2s; end
			STP_T_BB:  begin op_a = t_b; op_b = t_b; end
			STP_T_C:   begin op_a = div_p2(res_q[STP_T_BB], 12); op_b = t3s; end
			STP_P_SQ:  begin op_a = v1; op_b = v1; end
			STP_P_SQ6: begin op_a = res_q[STP_P_SQ]; op_b = p6s; end
			STP_P_V5:  begin op_a = v1; op_b = p5s; end
			STP_P_SQ3: begin op_a = res_q[STP_P_SQ]; op_b = p3s; end
			STP_P_V2:  begin op_a = v1; op_b = p2s; end
			STP_P_P1: begin
				op_a = 64'sd140737488355328 + div_p2(res_q[STP_P_SQ3], 8)
					+ (res_q[STP_P_V2] <<< 12);
				op_b = p1u;
			end
			STP_P_NUM: begin
				op_a = ((64'sd1048576 - $signed({44'd0, job_q.raw_p})) <<< 31) - v2;
				op_b = 64'sd3125;
			end
			STP_P_DIV: begin op_a = res_q[STP_P_NUM]; op_b = v1c; end
			STP_P_W9:  begin op_a = p9s; op_b = w; end
			STP_P_WW:  begin op_a = res_q[STP_P_W9]; op_b = w; end
			STP_P_P8:  begin op_a = p8s; op_b = res_q[STP_P_DIV]; end
			STP_P_SCL: begin op_a = div_p2(v4c, 1); op_b = 64'sd100; end
			STP_H_X5:  begin op_a = h5s; op_b = hx; end
			STP_H_X6:  begin op_a = hx; op_b = h6s; end
			STP_H_X3:  begin op_a = hx; op_b = h3u; end
			STP_H_AB: begin
				op_a = div_p2(res_q[STP_H_X6], 10);
				op_b = div_p2(res_q[STP_H_X3], 11) + 64'sd32768;
			end
			STP_H_C2: begin
				op_a = div_p2(res_q[STP_H_AB], 10) + 64'sd2097152;
				op_b = h2s;
			end
			STP_H_DA: begin
				op_a = hd;
				op_b = div_p2(res_q[STP_H_C2] + 64'sd8192, 14);
			end
			STP_H_QQ:  begin op_a = hq; op_b = hq; end
			STP_H_H1:  begin op_a = div_p2(res_q[STP_H_QQ], 7); op_b = h1u; end
			default: begin op_a = 64'sd0; op_b = 64'sd0; end
		endcase
	end

	assign mul_start = (state_q == ST_ISSUE) && (step_q != STP_P_DIV);
	assign div_start = (state_q == ST_ISSUE) && (step_q == STP_P_DIV);
	assign unit_done = (step_q == STP_P_DIV) ? div_done : mul_done;
	assign unit_res  = (step_q == STP_P_DIV) ? div_res : mul_res;

	esc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.result (mul_res)
	);

	esc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (op_a),
		.b      (op_b),
		.done   (div_done),
		.result (div_res)
	);

	// The pressure and humidity chains are skipped when their bit is clear.
	always_comb begin
		next_step = step_q + 1'b1;
		last_step = 1'b0;
		priority if (step_q == STP_T_C) begin
			if (job_q.do_press) begin
				next_step = STP_P_SQ;
			end else if (job_q.do_hum) begin
				next_step = STP_H_X5;
			end else begin
				last_step = 1'b1;
			end
		end else if (step_q == STP_P_SCL) begin
			if (job_q.do_hum) begin
				next_step = STP_H_X5;
			end else begin
				last_step = 1'b1;
			end
		end else if (step_q == STP_H_H1) begin
			last_step = 1'b1;
		end else begin
			next_step = step_q + 1'b1;
		end
	end

	// Clamping of the finished results.
	always_comb begin
		tt = div_p2((tf <<< 2) + tf + 64'sd128, 8);
		if (tt < TEMP_MIN) begin
			tt = TEMP_MIN;
		end else if (tt > TEMP_MAX) begin
			tt = TEMP_MAX;
		end
		temp_n = job_q.any ? tt[14:0] : 15'sd0;

		p32 = 32'(div_p2(res_q[STP_P_SCL], 7));
		if (v1c == 64'sd0) begin
			p32 = PRESS_MIN;
		end else if (p32 < PRESS_MIN) begin
			p32 = PRESS_MIN;
		end else if (p32 > PRESS_MAX) begin
			p32 = PRESS_MAX;
		end
		press_n = job_q.do_press ? p32[23:0] : 24'd0;

		hum_n = 17'd0;
		if (job_q.do_hum) begin
			if (hd2 < 64'sd0) begin
				hum_n = 17'd0;
			end else if (hd2 > HUM_MAX) begin
				hum_n = HUM_MAX[28:12];
			end else begin
				hum_n = hd2[28:12];
			end
		end
	end

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if ((state_q == ST_WAIT) && unit_done) begin
			res_q[step_q] <= unit_res;
		end
		if ((state_q == ST_DONE) && out_free) begin
			temperature_out <= temp_n;
			pressure_out    <= press_n;
			humidity_out    <= hum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= STP_T_A;
			out_valid <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						step_q  <= STP_T_A;
						state_q <= q_data.any ? ST_ISSUE : ST_DONE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (unit_done) begin
						if (last_step) begin
							state_q <= ST_DONE;
						end else begin
							step_q  <= next_step;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/env_sensor_compensation.sv =====
// Each beat with a nonzero mode runs the temperature steps, then the pressure steps (multiply steps on the
// shared 32x32 multiplier plus the 64-bit radix-2 divide) and the humidity steps if selected.
// Throughput is one beat per back-end run; a two-entry input queue
// and the output register let either side stall independently.
// Reset (arst_n, asynchronous) clears the queue, the sequencer, out_valid and all
// calibration registers to zero.
module env_sensor_compensation #(
	parameter int QueueDepth = esc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     mode,
	input  logic [19:0]                    raw_temperature,
	input  logic [19:0]                    raw_pressure,
	input  logic [15:0]                    raw_humidity,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [14:0]             temperature_out,
	output logic [23:0]                    pressure_out,
	output logic [16:0]                    humidity_out,
	input  logic                           cfg_we,
	input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import esc_pkg::*;

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_a_q, press_b_q;
	logic [55:0] mixed_q;
	logic [23:0] hum45_q;
	coef_t       coef;
	logic        q_valid, q_pop;
	job_t        q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q     <= '0;
			press_b_q     <= '0;
			mixed_q       <= '0;
			hum45_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEMP:    temp_coeffs_q <= cfg_data[47:0];
				CFG_PRESS_A: press_a_q     <= cfg_data;
				CFG_PRESS_B: press_b_q     <= cfg_data;
				CFG_MIXED:   mixed_q       <= cfg_data[55:0];
				CFG_HUM45:   hum45_q       <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.t1 = temp_coeffs_q[15:0];
		coef.t2 = temp_coeffs_q[31:16];
		coef.t3 = temp_coeffs_q[47:32];
		coef.p1 = press_a_q[15:0];
		coef.p2 = press_a_q[31:16];
		coef.p3 = press_a_q[47:32];
		coef.p4 = press_a_q[63:48];
		coef.p5 = press_b_q[15:0];
		coef.p6 = press_b_q[31:16];
		coef.p7 = press_b_q[47:32];
		coef.p8 = press_b_q[63:48];
		coef.p9 = mixed_q[15:0];
		coef.h1 = mixed_q[23:16];
		coef.h2 = mixed_q[39:24];
		coef.h3 = mixed_q[47:40];
		coef.h6 = mixed_q[55:48];
		coef.h4 = hum45_q[11:0];
		coef.h5 = hum45_q[23:12];
	end

	esc_front #(
		.Depth (QueueDepth)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.raw_humidity    (raw_humidity),
		.q_valid         (q_valid),
		.q_data          (q_data),
		.q_pop           (q_pop)
	);

	esc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_data          (q_data),
		.q_pop           (q_pop),
		.coef            (coef),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.temperature_out (temperature_out),
		.pressure_out    (pressure_out),
		.humidity_out    (humidity_out)
	);

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import esc_pkg::*;

	typedef struct packed {
		logic [14:0] temperature;
		logic [23:0] pressure;
		logic [16:0] humidity;
	} reading_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [2:0]            mode;
	logic [19:0]           raw_temperature;
	logic [19:0]           raw_pressure;
	logic [15:0]           raw_humidity;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [14:0]    temperature_out;
	logic [23:0]           pressure_out;
	logic [16:0]           humidity_out;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	env_sensor_compensation i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.raw_humidity    (raw_humidity),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.temperature_out (temperature_out),
		.pressure_out    (pressure_out),
		.humidity_out    (humidity_out),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// Local copy of the calibration registers.
	logic [47:0] cal_temp;
	logic [63:0] cal_press_a;
	logic [63:0] cal_press_b;
	logic [55:0] cal_mixed;
	logic [23:0] cal_hum45;

	reading_t pending_readings[$];
	int       error_count;
	int       samples_sent;
	int       readings_seen;
	int       cal_sets;
	int       burst_left;
	int       hold_left;
	bit       stall_heavy;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("tb_top failed");
		$finish;
	end

	function automatic longint sdiv(longint a, longint b);
		if (b == 0)
			return 0;
		if (b == -1)
			return -a;
		return a / b;
	endfunction

	function automatic longint fine_temperature(longint adc_t);
		longint t1, t2, t3, a, b;
		t1 = longint'(cal_temp[15:0]);
		t2 = longint'($signed(cal_temp[31:16]));
		t3 = longint'($signed(cal_temp[47:32]));
		a = adc_t / 8 - t1 * 2;
		b = adc_t / 16 - t1;
		a = (a * t2) / 2048;
		b = (((b * b) / 4096) * t3) / 16384;
		return a + b;
	endfunction

	function automatic logic [31:0] compensate_pressure(longint tf, longint adc_p);
		longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, v4, r;
		logic [31:0] p;
		p1 = longint'(cal_press_a[15:0]);
		p2 = longint'($signed(cal_press_a[31:16]));
		p3 = longint'($signed(cal_press_a[47:32]));
		p4 = longint'($signed(cal_press_a[63:48]));
		p5 = longint'($signed(cal_press_b[15:0]));
		p6 = longint'($signed(cal_press_b[31:16]));
		p7 = longint'($signed(cal_press_b[47:32]));
		p8 = longint'($signed(cal_press_b[63:48]));
		p9 = longint'($signed(cal_mixed[15:0]));
		v1 = tf - 128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + v1 * p5 * 64'sd131072;
		v2 = v2 + p4 * 64'sd34359738368;
		v1 = sdiv(v1 * v1 * p3, 256) + v1 * p2 * 64'sd4096;
		v1 = sdiv((64'sd140737488355328 + v1) * p1, 64'sd8589934592);
		if (v1 == 0)
			return PRESS_MIN;
		v4 = 64'sd1048576 - adc_p;
		v4 = sdiv((v4 * 64'sd2147483648 - v2) * 64'sd3125, v1);
		v1 = sdiv(p9 * (v4 / 8192) * (v4 / 8192), 64'sd33554432);
		v2 = sdiv(p8 * v4, 64'sd524288);
		v4 = sdiv(v4 + v1 + v2, 256) + p7 * 16;
		r = sdiv((v4 / 2) * 100, 128);
		p = r[31:0];
		if (p < PRESS_MIN)
			p = PRESS_MIN;
		else if (p > PRESS_MAX)
			p = PRESS_MAX;
		return p;
	endfunction

	function automatic logic [31:0] compensate_humidity(longint tf, longint adc_h);
		longint h1, h2, h3, h4, h5, h6, x, a, b, c, d;
		h1 = longint'(cal_mixed[23:16]);
		h2 = longint'($signed(cal_mixed[39:24]));
		h3 = longint'(cal_mixed[47:40]);
		h6 = longint'($signed(cal_mixed[55:48]));
		h4 = longint'($signed(cal_hum45[11:0]));
		h5 = longint'($signed(cal_hum45[23:12]));
		x = tf - 76800;
		a = adc_h * 16384;
		b = h4 * 1048576;
		c = h5 * x;
		d = sdiv(a - b - c + 16384, 32768);
		a = sdiv(x * h6, 1024);
		b = sdiv(x * h3, 2048);
		c = sdiv(a * (b + 32768), 1024) + 2097152;
		a = sdiv(c * h2 + 8192, 16384);
		b = d * a;
		c = sdiv(sdiv(b, 32768) * sdiv(b, 32768), 128);
		d = b - sdiv(c * h1, 16);
		if (d < 0)
			d = 0;
		if (d > HUM_MAX)
			d = HUM_MAX;
		d = d / 4096;
		if (d > 102400)
			d = 102400;
		return d[31:0];
	endfunction

	function automatic reading_t compensate(logic [2:0] sel, logic [19:0] rt,
			logic [19:0] rp, logic [15:0] rh);
		reading_t res;
		longint   tf, t;
		logic [31:0] p, h;
		res = '0;
		if (sel != 3'd0) begin
			tf = fine_temperature(longint'(rt));
			t = (tf * 5 + 128) / 256;
			if (t < TEMP_MIN)
				t = TEMP_MIN;
			else if (t > TEMP_MAX)
				t = TEMP_MAX;
			res.temperature = t[14:0];
			if (sel[0]) begin
				p = compensate_pressure(tf, longint'(rp));
				res.pressure = p[23:0];
			end
			if (sel[2]) begin
				h = compensate_humidity(tf, longint'(rh));
				res.humidity = h[16:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			readings_seen++;
			if (pending_readings.size() == 0) begin
				error_count++;
				$display("[%0t] reading with no sample outstanding", $time);
			end else begin
				want = pending_readings.pop_front();
				if (temperature_out !== want.temperature)
					report_mismatch("temperature_out", temperature_out,
						$signed(want.temperature));
				if (pressure_out !== want.pressure)
					report_mismatch("pressure_out", pressure_out, want.pressure);
				if (humidity_out !== want.humidity)
					report_mismatch("humidity_out", humidity_out, want.humidity);
			end
		end
	end

	// Receiver: a long hold when asked, otherwise randomly chosen calm and choppy stretches.
	initial begin
		int phase_left;
		out_stall <= 1'b0;
		phase_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (phase_left == 0) begin
					phase_left = $urandom_range(400, 20);
					stall_heavy = ($urandom_range(2, 0) != 0);
				end
				phase_left--;
				out_stall <= stall_heavy ? ($urandom_range(99, 0) < 40) : 1'b0;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_TEMP:    cal_temp    = value[47:0];
			CFG_PRESS_A: cal_press_a = value;
			CFG_PRESS_B: cal_press_b = value;
			CFG_MIXED:   cal_mixed   = value[55:0];
			CFG_HUM45:   cal_hum45   = value[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_calibration(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
			logic [55:0] mx, logic [23:0] h45);
		write_reg(CFG_TEMP, {16'd0, t});
		write_reg(CFG_PRESS_A, pa);
		write_reg(CFG_PRESS_B, pb);
		write_reg(CFG_MIXED, {8'd0, mx});
		write_reg(CFG_HUM45, {40'd0, h45});
		cfg_we <= 1'b0;
		cal_sets++;
	endtask

	// Calibration of a typical device, with optional jitter on every coefficient but p6.
	task automatic load_typical(int jitter);
		logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
		logic [7:0]  h1, h3, h6;
		logic [11:0] h4, h5;
		t1 = 16'd27504 + 16'($urandom_range(2 * jitter, 0) - jitter);
		t2 = 16'd26435 + 16'($urandom_range(2 * jitter, 0) - jitter);
		t3 = -16'sd1000 + 16'($urandom_range(2 * jitter, 0) - jitter);
		p1 = 16'd36477 + 16'($urandom_range(2 * jitter, 0) - jitter);
		p2 = -16'sd10685 + 16'($urandom_range(2 * jitter, 0) - jitter);
		p3 = 16'd3024 + 16'($urandom_range(2 * jitter, 0) - jitter);
		p4 = 16'd2855 + 16'($urandom_range(2 * jitter, 0) - jitter);
		p5 = 16'd140 + 16'($urandom_range(jitter / 8, 0));
		p6 = -16'sd7;
		p7 = 16'd15500 + 16'($urandom_range(2 * jitter, 0) - jitter);
		p8 = -16'sd14600 + 16'($urandom_range(2 * jitter, 0) - jitter);
		p9 = 16'd6000 + 16'($urandom_range(2 * jitter, 0) - jitter);
		h1 = 8'd75 + 8'($urandom_range(jitter / 32, 0));
		h2 = 16'd362 + 16'($urandom_range(jitter / 4, 0));
		h3 = 8'($urandom_range(jitter / 32, 0));
		h4 = 12'd313 + 12'($urandom_range(jitter / 8, 0));
		h5 = 12'd50 + 12'($urandom_range(jitter / 16, 0));
		h6 = 8'd30 + 8'($urandom_range(jitter / 64, 0));
		load_calibration({t3, t2, t1}, {p4, p3, p2, p1}, {p8, p7, p6, p5},
			{h6, h3, h2, h1, p9}, {h5, h4});
	endtask

	task automatic load_random_bits();
		load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
			{$urandom, $urandom}, 56'({$urandom, $urandom}), 24'($urandom));
	endtask

	task automatic send_sample(logic [2:0] sel, logic [19:0] rt, logic [19:0] rp,
			logic [15:0] rh);
		in_valid        <= 1'b1;
		mode            <= sel;
		raw_temperature <= rt;
		raw_pressure    <= rp;
		raw_humidity    <= rh;
		do
			@(posedge clk);
		while (in_stall);
		pending_readings.push_back(compensate(sel, rt, rp, rh));
		samples_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(12, 0);
			if ($urandom_range(1, 0)) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(300, 1)) @(posedge clk);
			end
		end
	endtask

	// Wait for every reading, then let the back end settle before touching registers.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_random_sample();
		logic [2:0]  sel;
		logic [19:0] rt, rp;
		logic [15:0] rh;
		sel = ($urandom_range(9, 0) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
		if ($urandom_range(9, 0) < 6) begin
			rt = 20'($urandom_range(620000, 420000));
			rp = 20'($urandom_range(600000, 200000));
		end else begin
			rt = 20'($urandom);
			rp = 20'($urandom);
		end
		rh = 16'($urandom);
		send_sample(sel, rt, rp, rh);
	endtask

	task automatic test_reset_calibration();
		// All coefficients zero: the pressure divisor is zero.
		send_sample(3'd0, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_sample(3'd7, 20'd0, 20'd0, 16'd0);
		send_sample(3'd7, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		drain();
	endtask

	task automatic test_directed();
		load_typical(0);
		for (int m = 0; m < 8; m++)
			send_sample(3'(m), 20'd519888, 20'd415148, 16'd29000);
		send_sample(3'd7, 20'd0, 20'd0, 16'd0);
		send_sample(3'd7, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_sample(3'd7, 20'd0, 20'hFFFFF, 16'hFFFF);
		send_sample(3'd7, 20'hFFFFF, 20'd0, 16'd0);
		send_sample(3'd5, 20'd300000, 20'd100000, 16'd60000);
		drain();
		// Extreme coefficient words drive the wrapping and clamping paths.
		load_calibration('1, '1, '1, '1, '1);
		send_sample(3'd7, 20'd519888, 20'd415148, 16'd29000);
		send_sample(3'd7, 20'hFFFFF, 20'd0, 16'hFFFF);
		drain();
		load_calibration({16'h7FFF, 16'h8000, 16'hFFFF}, {4{16'h8000}}, {4{16'h7FFF}},
			{8'h80, 8'hFF, 16'h8000, 8'hFF, 16'h7FFF}, {12'h800, 12'h7FF});
		send_sample(3'd7, 20'd519888, 20'd415148, 16'd29000);
		send_sample(3'd7, 20'd0, 20'hFFFFF, 16'd0);
		send_sample(3'd7, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0, 2: load_typical(1500);
				1:    load_typical(4000);
				default: load_random_bits();
			endcase
			repeat (180) send_random_sample();
			drain();
		end
	endtask

	task automatic test_backpressure();
		load_typical(500);
		hold_left = 600;
		repeat (40) begin
			burst_left = 40;
			send_random_sample();
		end
		drain();
	endtask

	initial begin
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		mode            <= '0;
		raw_temperature <= '0;
		raw_pressure    <= '0;
		raw_humidity    <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= '0;
		cfg_data        <= '0;
		cal_temp = '0;
		cal_press_a = '0;
		cal_press_b = '0;
		cal_mixed = '0;
		cal_hum45 = '0;
		hold_left = 0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_calibration();
		test_directed();
		test_backpressure();
		test_random();
		test_backpressure();

		if (pending_readings.size() != 0) begin
			error_count++;
			$display("%0d readings never arrived", pending_readings.size());
		end
		$display("Sent %0d samples over %0d calibration sets, %0d readings checked.",
			samples_sent, cal_sets, readings_seen);
		$display("Covered all component selects, extreme coefficients and long output holds.");
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== env_sensor_compensation.f =====
hw/rtl/esc_pkg.sv
hw/rtl/esc_front.sv
hw/rtl/esc_mul.sv
hw/rtl/esc_div.sv
hw/rtl/esc_back.sv
hw/rtl/env_sensor_compensation.sv
dv/tb_top.sv
